// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl, used by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/flacpr_pkg.sv =====
// shared types, constants and the fixed predictor table
package flacpr_pkg;

    localparam int MAX_ORDER = 32;
    localparam int COEF_BITS = 16;

    localparam int TAP_W  = $clog2(MAX_ORDER);
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int PROD_W = 32 + COEF_BITS;
    localparam int ACC_W  = PROD_W + TAP_W + 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QSHIFT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WASTED = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLKLEN = 3'd4;

    localparam logic [1:0] KIND_COEF  = 2'd0;
    localparam logic [1:0] KIND_WARM  = 2'd1;
    localparam logic [1:0] KIND_RESID = 2'd2;

    localparam logic MODE_FIXED = 1'b0;
    localparam logic MODE_LPC   = 1'b1;

    localparam logic [5:0] FIXED_MAX_ORDER = 6'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic [4:0]         coef_index;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               error;
        logic               last_of_block;
    } t_out_beat;

    typedef struct packed {
        logic clr;
        logic load;
    } t_mac_ctl;

    // polynomial predictor taps, newest sample at tap 0
    function automatic logic signed [COEF_BITS-1:0] fixed_coef(
        input logic [2:0]       order,
        input logic [TAP_W-1:0] tap
    );
        logic signed [COEF_BITS-1:0] c;
        c = '0;
        case (order)
            3'd1: begin
                if (tap == TAP_W'(0)) c = COEF_BITS'(1);
            end
            3'd2: begin
                if (tap == TAP_W'(0)) c = COEF_BITS'(2);
                if (tap == TAP_W'(1)) c = COEF_BITS'(-1);
            end
            3'd3: begin
                if (tap == TAP_W'(0)) c = COEF_BITS'(3);
                if (tap == TAP_W'(1)) c = COEF_BITS'(-3);
                if (tap == TAP_W'(2)) c = COEF_BITS'(1);
            end
            3'd4: begin
                if (tap == TAP_W'(0)) c = COEF_BITS'(4);
                if (tap == TAP_W'(1)) c = COEF_BITS'(-6);
                if (tap == TAP_W'(2)) c = COEF_BITS'(4);
                if (tap == TAP_W'(3)) c = COEF_BITS'(-1);
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/flacpr_store.sv =====
// sample history shift line and lpc coefficient registers
module flacpr_store
    import flacpr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_coef_we,
    input  logic [TAP_W-1:0]            i_coef_idx,
    input  logic signed [COEF_BITS-1:0] i_coef_data,
    input  logic                        i_push,
    input  logic [31:0]                 i_push_data,
    input  logic [TAP_W-1:0]            i_rd_tap,
    output logic signed [31:0]          o_hist_rd,
    output logic signed [COEF_BITS-1:0] o_coef_rd
);

    logic [31:0]                 r_hist [MAX_ORDER];
    logic signed [COEF_BITS-1:0] r_coef [MAX_ORDER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ORDER; i++) r_hist[i] <= '0;
        end else if (i_push) begin
            r_hist[0] <= i_push_data;
            for (int i = 1; i < MAX_ORDER; i++) r_hist[i] <= r_hist[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef[i_coef_idx] <= i_coef_data;
        end
    end

    assign o_hist_rd = $signed(r_hist[i_rd_tap]);
    assign o_coef_rd = r_coef[i_rd_tap];

endmodule

// ===== rtl/flacpr_mac.sv =====
// shared multiply-accumulate unit, product registered before the add
module flacpr_mac
    import flacpr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mac_ctl                    i_ctl,
    input  logic signed [31:0]          i_a,
    input  logic signed [COEF_BITS-1:0] i_b,
    output logic signed [ACC_W-1:0]     o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (i_ctl.clr) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/flac_predictor_restore_core.sv =====
// top level: sequencer, config registers, sample count and output register
//
//  channel | signals                         | beat taken when
//  --------+---------------------------------+-----------------------------
//  in      | i_in_valid o_in_stall i_in      | i_in_valid && !o_in_stall
//  out     | o_out_valid i_out_stall o_out   | o_out_valid && !i_out_stall
//  cfg     | i_cfg_we i_cfg_addr i_cfg_wdata | i_cfg_we
//
// coefficient beats are written in idle; warm-ups pass predict and finish; residuals
// with n taps (1..32) pass multiply, flush, predict and finish, or only predict and
// finish with no taps (order 0, or fixed above 4); one tap a cycle on the multiplier
// reset is synchronous, active low: history zero, count zero, registers to
// defaults; coefficients hold no reset value until written
// a held result stalls the sequencer in its final step until the beat leaves

`include "assert_macros.svh"

module flac_predictor_restore_core
    import flacpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MAC   = 5'b00010,
        S_FLUSH = 5'b00100,
        S_PRED  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic        r_mode;
    logic [5:0]  r_order;
    logic [4:0]  r_qshift;
    logic [4:0]  r_wasted;
    logic [16:0] r_blklen;
    logic [16:0] r_count;

    logic [TAP_W-1:0]   r_tap;
    logic [ORD_W-1:0]   r_ntaps;
    logic               r_err;
    logic               r_resid;
    logic [31:0]        r_val;
    logic [31:0]        r_pred;
    t_out_beat          r_out;
    logic               r_out_vld;

    logic                        in_acc;
    logic                        is_sample;
    logic                        fix_err;
    logic [ORD_W-1:0]            lpc_taps;
    logic [ORD_W-1:0]            new_taps;
    logic                        fin_go;
    logic [31:0]                 s_val;
    logic [16:0]                 blk_len;
    logic [16:0]                 cnt_inc;
    logic                        cnt_last;
    t_mac_ctl                    mac_ctl;
    logic signed [31:0]          hist_rd;
    logic signed [COEF_BITS-1:0] coef_rd;
    logic signed [COEF_BITS-1:0] mac_b;
    logic signed [ACC_W-1:0]     acc;
    logic [4:0]                  shamt;
    logic signed [ACC_W-1:0]     acc_sh;
    logic                        coef_we;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_sample  = (i_in.kind == KIND_WARM) || (i_in.kind == KIND_RESID);
    assign coef_we    = in_acc && (i_in.kind == KIND_COEF) && (int'(i_in.coef_index) < MAX_ORDER);
    assign fix_err    = (r_mode == MODE_FIXED) && (r_order > FIXED_MAX_ORDER);

    assign lpc_taps = (int'(r_order) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(r_order);
    always_comb begin
        if (fix_err || i_in.kind != KIND_RESID) begin
            new_taps = '0;
        end else begin
            new_taps = lpc_taps;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FIXED;
            r_order  <= '0;
            r_qshift <= '0;
            r_wasted <= '0;
            r_blklen <= 17'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:   r_mode   <= i_cfg_wdata[0];
                REG_ORDER:  r_order  <= i_cfg_wdata[5:0];
                REG_QSHIFT: r_qshift <= i_cfg_wdata[4:0];
                REG_WASTED: r_wasted <= i_cfg_wdata[4:0];
                REG_BLKLEN: r_blklen <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // sequencer
    assign fin_go = (r_state == S_FIN) && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_sample) begin
                    n_state = (new_taps == '0) ? S_PRED : S_MAC;
                end
            end
            S_MAC: begin
                if (r_tap == TAP_W'(r_ntaps - ORD_W'(1))) n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_PRED;
            S_PRED:  n_state = S_FIN;
            S_FIN: begin
                if (fin_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_sample) begin
            r_tap   <= '0;
            r_ntaps <= new_taps;
            r_err   <= fix_err;
            r_resid <= (i_in.kind == KIND_RESID);
            r_val   <= i_in.value;
        end else if (r_state == S_MAC) begin
            r_tap <= r_tap + TAP_W'(1);
        end
    end

    // shared multiply-accumulate
    assign mac_ctl.clr  = in_acc && is_sample;
    assign mac_ctl.load = (r_state == S_MAC);
    assign mac_b = (r_mode == MODE_LPC) ? coef_rd : fixed_coef(r_order[2:0], r_tap);

    flacpr_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef_we   (coef_we),
        .i_coef_idx  (TAP_W'(i_in.coef_index)),
        .i_coef_data (i_in.value[COEF_BITS-1:0]),
        .i_push      (fin_go && !r_err),
        .i_push_data (s_val),
        .i_rd_tap    (r_tap),
        .o_hist_rd   (hist_rd),
        .o_coef_rd   (coef_rd)
    );

    flacpr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (hist_rd),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    // quantization shift applies to lpc only
    assign shamt  = (r_mode == MODE_LPC) ? r_qshift : 5'd0;
    assign acc_sh = acc >>> shamt;

    always_ff @(posedge i_clk) begin
        if (r_state == S_PRED) begin
            r_pred <= acc_sh[31:0];
        end
    end

    assign s_val = r_resid ? (r_val + r_pred) : r_val;

    // block position
    assign blk_len  = (r_blklen == '0) ? 17'd1 : r_blklen;
    assign cnt_inc  = r_count + 17'd1;
    assign cnt_last = (cnt_inc == blk_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (fin_go) begin
            r_count <= cnt_last ? 17'd0 : cnt_inc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.sample        <= r_err ? 32'sd0 : $signed(s_val << r_wasted);
            r_out.error         <= r_err;
            r_out.last_of_block <= cnt_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `ASSERT_IMPL(a_tap_in_range, r_state == S_MAC,
        (r_ntaps != '0) && (int'(r_tap) < int'(r_ntaps)), "tap counter past tap count")
    `ASSERT_IMPL(a_err_zero, o_out_valid && o_out.error,
        o_out.sample == 32'sd0, "error result carries a nonzero sample")
    `ASSERT_NEXT(a_sample_busy, in_acc && is_sample,
        r_state != S_IDLE, "sample beat accepted without leaving idle")
    `ASSERT_NEXT(a_fin_result, fin_go, o_out_valid, "finished sample not presented")

endmodule

// ===== tb/sv/tb_flac_predictor_restore_core.sv =====
// self-checking testbench for the flac predictor restore core
module tb_flac_predictor_restore_core
    import flacpr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         TARGET_BEATS = 1400;
    localparam int         SETTLE_CYCLES = 48;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         CYCLE_LIMIT  = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out;

    flac_predictor_restore_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the block state and registers
    logic                        mode_q = MODE_FIXED;
    logic [5:0]                  order_q = '0;
    logic [4:0]                  qshift_q = '0;
    logic [4:0]                  wasted_q = '0;
    logic [16:0]                 blklen_q = 17'd4096;
    logic [31:0]                 hist_q [MAX_ORDER];
    logic signed [COEF_BITS-1:0] taps_q [MAX_ORDER];
    logic [16:0]                 count_q = '0;

    t_in_beat  pending_beats[$];
    t_out_beat expected_samples[$];
    t_out_beat want_beat;
    t_out_beat got_beat;

    int  mismatch_count = 0;
    int  samples_checked = 0;
    int  beats_queued = 0;
    int  settings_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  in_taken = 1'b0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    initial begin
        for (int i = 0; i < MAX_ORDER; i++) begin
            hist_q[i] = '0;
            taps_q[i] = '0;
        end
    end

    // returns 1 when the beat yields a sample, and updates the predictor state
    function automatic bit restore_sample(input t_in_beat b, output t_out_beat r);
        logic [31:0]        pred;
        logic [31:0]        s;
        logic signed [63:0] acc;
        logic signed [63:0] shifted;
        logic signed [63:0] h64;
        logic signed [63:0] c64;
        logic [16:0]        len;
        int                 n;
        r = '0;
        if (b.kind == KIND_COEF) begin
            taps_q[b.coef_index] = b.value[COEF_BITS-1:0];
            return 1'b0;
        end
        if (b.kind != KIND_WARM && b.kind != KIND_RESID)
            return 1'b0;
        if (mode_q == MODE_FIXED && order_q > FIXED_MAX_ORDER) begin
            r.error = 1'b1;
        end else begin
            pred = '0;
            if (mode_q == MODE_FIXED) begin
                case (order_q)
                    6'd1: pred = hist_q[0];
                    6'd2: pred = 32'd2 * hist_q[0] - hist_q[1];
                    6'd3: pred = 32'd3 * hist_q[0] - 32'd3 * hist_q[1] + hist_q[2];
                    6'd4: pred = 32'd4 * hist_q[0] - 32'd6 * hist_q[1]
                                 + 32'd4 * hist_q[2] - hist_q[3];
                    default: pred = '0;
                endcase
            end else begin
                n = (order_q > MAX_ORDER) ? MAX_ORDER : int'(order_q);
                acc = '0;
                for (int j = 0; j < n; j++) begin
                    h64 = $signed(hist_q[j]);
                    c64 = taps_q[j];
                    acc += h64 * c64;
                end
                shifted = acc >>> qshift_q;
                pred = shifted[31:0];
            end
            s = (b.kind == KIND_WARM) ? b.value : b.value + pred;
            for (int i = MAX_ORDER - 1; i > 0; i--)
                hist_q[i] = hist_q[i-1];
            hist_q[0] = s;
            r.sample = s << wasted_q;
        end
        len = (blklen_q == '0) ? 17'd1 : blklen_q;
        count_q = count_q + 17'd1;
        if (count_q == len) begin
            r.last_of_block = 1'b1;
            count_q = '0;
        end
        return 1'b1;
    endfunction

    // mostly no idle, sometimes a short gap, rarely a long stretch
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(0, 512) - 256;
        endcase
    endfunction

    // upper bits are junk, only the low coefficient bits matter
    function automatic logic [31:0] rand_coef();
        logic [15:0] lo;
        case ($urandom_range(0, 7))
            0: lo = 16'h8000;
            1: lo = 16'h7fff;
            2, 3: lo = 16'($urandom());
            default: lo = 16'($urandom_range(0, 2047) - 1024);
        endcase
        return {16'($urandom()), lo};
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                i_in <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                gap_left = no_idle ? 0 : pick_idle();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // accepted input beats feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_taken = 1'b1;
            if (restore_sample(i_in, want_beat))
                expected_samples.push_back(want_beat);
        end
    end

    // output stall, with the long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && !no_idle) begin
            stall_left = pick_idle();
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_beat = o_out;
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %p", $time, got_beat);
                mismatch_count++;
            end else begin
                want_beat = expected_samples.pop_front();
                samples_checked++;
                if (got_beat.sample !== want_beat.sample) begin
                    $display("%0t: sample mismatch, expected %h, got %h",
                             $time, want_beat.sample, got_beat.sample);
                    mismatch_count++;
                end
                if (got_beat.error !== want_beat.error) begin
                    $display("%0t: error flag mismatch, expected %b, got %b",
                             $time, want_beat.error, got_beat.error);
                    mismatch_count++;
                end
                if (got_beat.last_of_block !== want_beat.last_of_block) begin
                    $display("%0t: last flag mismatch, expected %b, got %b",
                             $time, want_beat.last_of_block, got_beat.last_of_block);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d samples outstanding",
                     $time, expected_samples.size());
            $display("FAIL flac_predictor_restore_core");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        case (addr)
            REG_MODE:   mode_q = data[0];
            REG_ORDER:  order_q = data[5:0];
            REG_QSHIFT: qshift_q = data[4:0];
            REG_WASTED: wasted_q = data[4:0];
            REG_BLKLEN: blklen_q = data[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic mode, input logic [5:0] order,
                                 input logic [4:0] qshift, input logic [4:0] wasted,
                                 input logic [16:0] blklen);
        write_reg(REG_MODE, CFG_DATA_W'(mode));
        write_reg(REG_ORDER, CFG_DATA_W'(order));
        write_reg(REG_QSHIFT, CFG_DATA_W'(qshift));
        write_reg(REG_WASTED, CFG_DATA_W'(wasted));
        write_reg(REG_BLKLEN, CFG_DATA_W'(blklen));
        settings_count++;
    endtask

    task automatic push_beat(input logic [1:0] kind, input logic [31:0] value,
                             input logic [4:0] idx);
        t_in_beat b;
        b.kind = kind;
        b.value = value;
        b.coef_index = idx;
        pending_beats.push_back(b);
        if (kind != KIND_UNUSED)
            beats_queued++;
    endtask

    // all beats sent, all samples back, then let coefficient writes settle
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one subframe: taps, warm-ups, residuals, with some noise mixed in
    task automatic random_subframe(input int min_res);
        logic        mode;
        logic [5:0]  order;
        logic [4:0]  qshift;
        logic [4:0]  wasted;
        logic [16:0] blklen;
        int          n_taps;
        int          n_warm;
        int          n_res;
        int          pick;
        mode = ($urandom_range(0, 1) == 0) ? MODE_FIXED : MODE_LPC;
        pick = $urandom_range(0, 9);
        if (mode == MODE_FIXED)
            order = (pick < 8) ? 6'($urandom_range(0, 4)) : 6'($urandom_range(5, 63));
        else if (pick == 0)
            order = 6'($urandom_range(33, 63));
        else if (pick == 1)
            order = 6'd32;
        else if (pick == 2)
            order = 6'($urandom_range(17, 31));
        else
            order = 6'($urandom_range(0, 16));
        pick = $urandom_range(0, 9);
        qshift = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : 5'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        wasted = (pick < 5) ? 5'd0 : (pick == 5) ? 5'd31 : 5'($urandom());
        case ($urandom_range(0, 9))
            0: blklen = 17'd0;
            1: blklen = 17'd1;
            2: blklen = 17'd65536;
            3: blklen = 17'h1ffff;
            default: blklen = 17'($urandom_range(2, 48));
        endcase
        apply_setting(mode, order, qshift, wasted, blklen);

        n_taps = (order > MAX_ORDER) ? MAX_ORDER : int'(order);
        if (mode == MODE_LPC)
            for (int t = 0; t < n_taps; t++)
                push_beat(KIND_COEF, rand_coef(), 5'(t));
        if (mode == MODE_FIXED && order > FIXED_MAX_ORDER)
            n_warm = $urandom_range(0, 4);
        else
            n_warm = n_taps;
        // now and then a subframe that skips some warm-ups
        if ($urandom_range(0, 9) == 0)
            n_warm = $urandom_range(0, n_warm);
        for (int w = 0; w < n_warm; w++)
            push_beat(KIND_WARM, rand_sample(), 5'($urandom()));
        n_res = $urandom_range(min_res, 40);
        for (int k = 0; k < n_res; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                push_beat(KIND_UNUSED, $urandom(), 5'($urandom()));
            else if (pick < 7)
                push_beat(KIND_COEF, rand_coef(), 5'($urandom()));
            else
                push_beat(KIND_RESID, rand_sample(), 5'($urandom()));
        end
    endtask

    initial begin
        int subframes;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: fixed order zero, samples pass through unshifted
        push_beat(KIND_WARM, 32'h7fff_ffff, 5'd0);
        push_beat(KIND_WARM, 32'h8000_0000, 5'd31);
        push_beat(KIND_RESID, 32'h7fff_ffff, 5'd0);
        push_beat(KIND_RESID, 32'h8000_0000, 5'd0);
        push_beat(KIND_UNUSED, 32'hffff_ffff, 5'd31);
        wait_idle();

        // fourth order polynomial with wrap, max shift, zero length means every sample last
        apply_setting(MODE_FIXED, 6'd4, 5'd0, 5'd31, 17'd0);
        push_beat(KIND_WARM, 32'd1, 5'd0);
        push_beat(KIND_WARM, 32'hffff_ffff, 5'd0);
        push_beat(KIND_WARM, 32'h7fff_ffff, 5'd0);
        push_beat(KIND_WARM, 32'h8000_0000, 5'd0);
        push_beat(KIND_RESID, 32'h7fff_ffff, 5'd0);
        push_beat(KIND_RESID, 32'hffff_ffff, 5'd0);
        wait_idle();

        // fixed order beyond four reports errors
        apply_setting(MODE_FIXED, 6'd5, 5'd0, 5'd0, 17'd3);
        push_beat(KIND_WARM, 32'd5, 5'd0);
        push_beat(KIND_RESID, 32'd0, 5'd0);
        wait_idle();

        // lpc with extreme taps and largest quantizer shift
        apply_setting(MODE_LPC, 6'd2, 5'd31, 5'd1, 17'd2);
        push_beat(KIND_COEF, 32'hffff_8000, 5'd0);
        push_beat(KIND_COEF, 32'h0001_7fff, 5'd1);
        push_beat(KIND_COEF, 32'h0000_0000, 5'd31);
        push_beat(KIND_WARM, 32'h8000_0000, 5'd0);
        push_beat(KIND_WARM, 32'h7fff_ffff, 5'd0);
        push_beat(KIND_RESID, 32'h7fff_ffff, 5'd0);
        push_beat(KIND_RESID, 32'd0, 5'd0);
        wait_idle();

        // lpc order zero predicts nothing
        apply_setting(MODE_LPC, 6'd0, 5'd0, 5'd0, 17'd4096);
        push_beat(KIND_RESID, 32'd12345, 5'd0);
        wait_idle();

        subframes = 0;
        while (beats_queued < TARGET_BEATS) begin
            if (subframes == 2 || subframes == 15) begin
                // receiver holds off while the sender keeps going
                no_idle = 1'b1;
                hold_req = 1'b1;
                random_subframe(30);
            end else begin
                no_idle = ($urandom_range(0, 3) == 0);
                random_subframe(4);
            end
            wait_idle();
            subframes++;
        end
        no_idle = 1'b0;

        $display("covered %0d beats over %0d register settings, %0d samples checked",
                 beats_queued, settings_count, samples_checked);
        if (mismatch_count == 0)
            $display("PASS flac_predictor_restore_core");
        else
            $display("FAIL flac_predictor_restore_core");
        $finish;
    end

endmodule
